### src/erle_pkg.sv
package erle_pkg;

    localparam logic [7:0]  ESCAPE_CODE      = 8'hC0;
    localparam logic [15:0] LENGTH_RESET     = 16'd32058;
    localparam int          BYTES_PER_RESULT = 4;
    localparam int          BYTE_FIELDS      = 4;
    localparam int          CHUNK            = (BYTES_PER_RESULT > BYTE_FIELDS) ? BYTE_FIELDS
                                                                               : BYTES_PER_RESULT;
    localparam int          COUNT_W          = 3;
    localparam int          TDATA_W          = 40;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_VALUE = 2'd1,
        PH_COUNT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        TOK_NONE = 2'd0,
        TOK_LIT  = 2'd1,
        TOK_RUN  = 2'd2
    } tok_kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } emit_state_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] value;
        logic [7:0] count;
        logic       fin;
    } token_t;

endpackage

### src/erle_parse.sv
module erle_parse
    import erle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_length_we,
    input  logic [15:0] stream_length_wdata,
    input  logic        take,
    input  logic [7:0]  data_byte,
    output token_t      tok
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  value_reg, value_next;
    logic [15:0] consumed_reg, consumed_next;
    logic [15:0] length_reg;
    logic [15:0] consumed_inc;
    logic        token_done;
    logic        completes;

    assign consumed_inc = (consumed_reg == 16'hFFFF) ? consumed_reg : consumed_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        value_next = value_reg;
        token_done = 1'b0;
        tok.kind   = TOK_NONE;
        tok.value  = data_byte;
        tok.count  = data_byte;
        case (phase_reg)
            PH_VALUE:
            begin
                value_next = data_byte;
                phase_next = PH_COUNT;
            end
            PH_COUNT:
            begin
                phase_next = PH_LEAD;
                token_done = 1'b1;
                tok.kind   = TOK_RUN;
                tok.value  = value_reg;
            end
            default:
            begin
                if (data_byte == ESCAPE_CODE)
                begin
                    phase_next = PH_VALUE;
                end
                else
                begin
                    phase_next = PH_LEAD;
                    token_done = 1'b1;
                    tok.kind   = TOK_LIT;
                end
            end
        endcase
        completes     = token_done && (consumed_inc >= length_reg);
        tok.fin       = completes;
        consumed_next = completes ? 16'd0 : consumed_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            value_reg    <= 8'd0;
            consumed_reg <= 16'd0;
            length_reg   <= LENGTH_RESET;
        end
        else
        begin
            if (take)
            begin
                phase_reg    <= phase_next;
                value_reg    <= value_next;
                consumed_reg <= consumed_next;
            end
            if (stream_length_we)
            begin
                length_reg <= stream_length_wdata;
            end
        end
    end

endmodule

### src/erle_emit.sv
module erle_emit
    import erle_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  token_t                       tok,
    output logic                         idle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [BYTE_FIELDS-1:0][7:0]  out_bytes,
    output logic [COUNT_W-1:0]           out_count,
    output logic                         out_last,
    output logic                         out_fin
);

    emit_state_t                  state_reg, state_next;
    logic [7:0]                   left_reg, left_next;
    logic [7:0]                   value_reg, value_next;
    logic                         fin_reg, fin_next;
    logic                         valid_reg, valid_next;
    logic [BYTE_FIELDS-1:0][7:0]  bytes_reg, bytes_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic                         last_reg, last_next;
    logic                         ofin_reg, ofin_next;
    logic                         slot_free;
    logic [7:0]                   step;
    logic [7:0]                   rem;

    assign slot_free = !valid_reg || out_ready;
    assign idle      = (state_reg == ST_IDLE) && slot_free;

    assign step = (left_reg > 8'(CHUNK)) ? 8'(CHUNK) : left_reg;
    assign rem  = left_reg - step;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && tok.kind == TOK_RUN && tok.count != 8'd0)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free && rem == 8'd0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        left_next  = left_reg;
        value_next = value_reg;
        fin_next   = fin_reg;
        valid_next = valid_reg && !out_ready;
        bytes_next = bytes_reg;
        count_next = count_reg;
        last_next  = last_reg;
        ofin_next  = ofin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (tok.kind)
                        TOK_LIT:
                        begin
                            valid_next = 1'b1;
                            bytes_next = '0;
                            bytes_next[0] = tok.value;
                            count_next = COUNT_W'(1);
                            last_next  = 1'b1;
                            ofin_next  = tok.fin;
                        end
                        TOK_RUN:
                        begin
                            left_next  = tok.count;
                            value_next = tok.value;
                            fin_next   = tok.fin;
                            if (tok.count == 8'd0 && tok.fin)
                            begin
                                valid_next = 1'b1;
                                bytes_next = '0;
                                count_next = '0;
                                last_next  = 1'b1;
                                ofin_next  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    valid_next = 1'b1;
                    for (int j = 0; j < BYTE_FIELDS; j++)
                    begin
                        bytes_next[j] = (8'(j) < step) ? value_reg : 8'd0;
                    end
                    count_next = step[COUNT_W-1:0];
                    last_next  = (rem == 8'd0);
                    ofin_next  = (rem == 8'd0) && fin_reg;
                    left_next  = rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            left_reg  <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        fin_reg   <= fin_next;
        bytes_reg <= bytes_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        ofin_reg  <= ofin_next;
    end

    assign out_valid = valid_reg;
    assign out_bytes = bytes_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;
    assign out_fin   = ofin_reg;

endmodule

### src/escape_rle_byte_decoder_core.sv
// Escape-byte run-length decoder.
// Slave stream: one compressed byte per transfer on s_tdata.
// Master stream: up to four decoded bytes per transfer with a byte count,
// m_tlast on the last transfer caused by one input byte, m_tuser on the
// transfer that completes the configured stream.
// stream_length_we/stream_length_wdata write the stream length in bytes;
// write it only while the block is idle.
// A literal appears on the master side in the cycle after its transfer.
// On its count byte a run of N bytes loads the remaining count and enters
// the run state, which gives ceil(N/4) transfers, one per cycle while the
// master side is ready, from a shared 8-bit compare/subtract step on the
// remaining count; s_tready stays low meanwhile. Escape and value bytes
// give no output. Literals go one byte per cycle unless the master side
// stalls; a stalled master side holds the output register and s_tready.
// Reset clears the decode phase, the byte counter and the output valid,
// and sets the stream length to 32058.
module escape_rle_byte_decoder_core
    import erle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stream_length_we,
    input  logic [15:0]        stream_length_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_byte0..3, valid_count, zero pad
    output logic               m_tlast,   // run_last
    output logic               m_tuser    // stream_end
);

    token_t                      tok;
    logic                        take;
    logic                        idle;
    logic [BYTE_FIELDS-1:0][7:0] out_bytes;
    logic [COUNT_W-1:0]          out_count;

    assign s_tready = idle;
    assign take     = s_tvalid && idle;

    erle_parse u_parse (
        .clk                 (clk),
        .rst_n               (rst_n),
        .stream_length_we    (stream_length_we),
        .stream_length_wdata (stream_length_wdata),
        .take                (take),
        .data_byte           (s_tdata),
        .tok                 (tok)
    );

    erle_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .tok       (tok),
        .idle      (idle),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bytes (out_bytes),
        .out_count (out_count),
        .out_last  (m_tlast),
        .out_fin   (m_tuser)
    );

    assign m_tdata = {{(TDATA_W - 8 * BYTE_FIELDS - COUNT_W){1'b0}}, out_count, out_bytes};

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:32] <= 3'd4))
        else $error("byte count above four");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream end on a transfer that is not last of its byte");

    a_full_inner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[34:32] == 3'd4))
        else $error("partial transfer inside a run");

    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[34:32] == 3'd0) |-> m_tuser)
        else $error("empty transfer without stream end");

endmodule

### tb/tb_escape_rle_byte_decoder_core.sv
`timescale 1ns / 1ps

module tb_escape_rle_byte_decoder_core;
    import erle_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;
    localparam int SHOW_MAX    = 10;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 53;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            run_end;
        logic            stream_done;
    } chunk_t;

    logic               clk                 = 1'b0;
    logic               rst_n               = 1'b0;
    logic               stream_length_we    = 1'b0;
    logic [15:0]        stream_length_wdata = '0;
    logic               s_tvalid            = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata             = '0;
    logic               m_tvalid;
    logic               m_tready            = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    phase_t      dec_phase  = PH_LEAD;
    logic [7:0]  run_byte   = '0;
    logic [15:0] byte_tally = '0;
    logic [15:0] stream_len = LENGTH_RESET;

    logic [7:0]  pending_bytes[$];
    chunk_t      expected_chunks[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned src_wait;
    int unsigned snk_wait;
    bit          src_gaps_on = 1'b1;
    bit          snk_gaps_on = 1'b1;

    escape_rle_byte_decoder_core u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .stream_length_we    (stream_length_we),
        .stream_length_wdata (stream_length_wdata),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tlast             (m_tlast),
        .m_tuser             (m_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("escape_rle_byte_decoder_core test failed");
            $finish;
        end
    end

    // count one compressed byte; report whether it closes the stream
    function automatic bit tally_byte(input bit token_done);
        if (byte_tally != 16'hFFFF)
            byte_tally = byte_tally + 16'd1;
        if (token_done && byte_tally >= stream_len)
        begin
            byte_tally = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_chunk(input logic [7:0] value, input int n,
                                       input bit last, input bit done);
        chunk_t c;
        c.bytes = '0;
        for (int j = 0; j < BYTE_FIELDS; j++)
            if (j < n)
                c.bytes[j] = value;
        c.cnt         = 3'(n);
        c.run_end     = last;
        c.stream_done = done;
        expected_chunks.push_back(c);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int left;
        int n;
        bit done;
        case (dec_phase)
            PH_VALUE:
            begin
                run_byte  = b;
                dec_phase = PH_COUNT;
                void'(tally_byte(1'b0));
            end
            PH_COUNT:
            begin
                dec_phase = PH_LEAD;
                done      = tally_byte(1'b1);
                left      = b;
                if (left == 0)
                begin
                    if (done)
                        push_chunk(8'h00, 0, 1'b1, 1'b1);
                end
                while (left > 0)
                begin
                    n    = (left > CHUNK) ? CHUNK : left;
                    left = left - n;
                    push_chunk(run_byte, n, left == 0, (left == 0) && done);
                end
            end
            default:
            begin
                if (b == ESCAPE_CODE)
                begin
                    dec_phase = PH_VALUE;
                    void'(tally_byte(1'b0));
                end
                else
                begin
                    dec_phase = PH_LEAD;
                    done      = tally_byte(1'b1);
                    push_chunk(b, 1, 1'b1, done);
                end
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void check_chunk(input logic [TDATA_W-1:0] data, input logic last,
                                        input logic fin);
        chunk_t     want;
        chunk_t     got;
        logic [4:0] pad;
        got.bytes       = data[31:0];
        got.cnt         = data[34:32];
        got.run_end     = last;
        got.stream_done = fin;
        pad             = data[TDATA_W-1:35];
        if (expected_chunks.size() == 0)
        begin
            note_mismatch($sformatf("unexpected transfer: tdata %h tlast %b tuser %b",
                                    data, last, fin));
            return;
        end
        want = expected_chunks.pop_front();
        for (int j = 0; j < BYTE_FIELDS; j++)
            if (got.bytes[j] !== want.bytes[j])
                note_mismatch($sformatf("out_byte%0d: expected %h, got %h",
                                        j, want.bytes[j], got.bytes[j]));
        if (got.cnt !== want.cnt)
            note_mismatch($sformatf("valid_count: expected %0d, got %0d", want.cnt, got.cnt));
        if (pad !== 5'd0)
            note_mismatch($sformatf("tdata pad: expected 0, got %h", pad));
        if (got.run_end !== want.run_end)
            note_mismatch($sformatf("run_last: expected %b, got %b",
                                    want.run_end, got.run_end));
        if (got.stream_done !== want.stream_done)
            note_mismatch($sformatf("stream_end: expected %b, got %b",
                                    want.stream_done, got.stream_done));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (src_wait != 0)
                begin
                    src_wait <= src_wait - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    s_tdata  <= pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    src_wait <= src_gaps_on ? $urandom_range(0, 5) : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : observe
        int unsigned w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_chunk(m_tdata, m_tlast, m_tuser);
            w = snk_gaps_on ? $urandom_range(0, 5) : 0;
            if (w != 0)
            begin
                m_tready <= 1'b0;
                snk_wait <= w - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
        else if (snk_wait != 0)
        begin
            snk_wait <= snk_wait - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_literal();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == ESCAPE_CODE);
        return b;
    endfunction

    function automatic void add_run(input logic [7:0] value, input logic [7:0] count);
        pending_bytes.push_back(ESCAPE_CODE);
        pending_bytes.push_back(value);
        pending_bytes.push_back(count);
    endfunction

    function automatic void add_random_token();
        int unsigned r;
        int unsigned k;
        logic [7:0]  count;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            pending_bytes.push_back(rand_literal());
        end
        else if (r < 92)
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                count = 8'($urandom_range(0, 12));
            else if (k < 95)
                count = 8'($urandom_range(13, 64));
            else
                count = 8'($urandom_range(65, 255));
            add_run(8'($urandom_range(0, 255)), count);
        end
        else if (r < 96)
        begin
            // broken triple: escape then whatever comes next
            pending_bytes.push_back(ESCAPE_CODE);
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic write_length(input logic [15:0] len);
        @(posedge clk);
        stream_length_we    <= 1'b1;
        stream_length_wdata <= len;
        @(posedge clk);
        stream_length_we    <= 1'b0;
        stream_len = len;
    endtask

    // hold until every byte is taken and every result has arrived
    task automatic drain();
        @(negedge clk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_chunks.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int unsigned idx;
        int unsigned sent;
        int          fill;
        logic [15:0] len;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset length: nothing completes here
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hC1);
        add_run(8'hC0, 8'd255);
        add_run(8'h3C, 8'd0);
        add_run(8'h01, 8'd1);
        add_run(8'hFE, 8'd5);
        drain();

        // zero length: every token closes a stream, empty completion
        write_length(16'd0);
        pending_bytes.push_back(8'h7E);
        add_run(8'h11, 8'd0);
        drain();

        // triple across the limit
        write_length(16'd3);
        pending_bytes.push_back(8'h44);
        add_run(8'h66, 8'd2);
        drain();

        for (idx = 0; idx < RAND_PHASES; idx++)
        begin
            case (idx)
                0:       len = 16'd1;
                1:       len = 16'hFFFF;
                2:       len = 16'($urandom_range(2, 6));
                5:       len = 16'($urandom_range(1, 65535));
                7:       len = 16'($urandom_range(30, 200));
                default: len = 16'($urandom_range(2, 30));
            endcase
            write_length(len);
            src_gaps_on = (idx % 4 == 0) || (idx % 4 == 2);
            snk_gaps_on = (idx % 4 == 0) || (idx % 4 == 1);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                fill = pending_bytes.size();
                add_random_token();
                sent += pending_bytes.size() - fill;
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("escape_rle_byte_decoder_core test passed");
        else
            $display("escape_rle_byte_decoder_core test failed");
        $finish;
    end

endmodule
